// ===== hdl/chti_pkg.sv =====
// chti_pkg: shared constants, status codes and the elf/pjw byte hash step
// for the chained hash table; no dependencies
package chti_pkg;

    // configuration port
    localparam int CFG_W   = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_BUCKETS = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam logic [CFG_W-1:0] RST_BUCKETS = 9'd256;
    localparam logic [CFG_W-1:0] RST_LIMIT   = 9'd256;

    // parameter defaults
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_MAX_BUCKETS = 256;

    // request kinds
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // hash: top nibble is always cleared, so 28 significant bits
    localparam logic [31:0] HASH_MUL  = 32'h0000_0010;
    localparam logic [31:0] HASH_TOP  = 32'hF000_0000;
    localparam int          HASH_FOLD = 24;
    localparam int          HASH_W    = 28;

    // modulo reduction, hash bits consumed per cycle
    localparam int MOD_BITS   = 4;
    localparam int MOD_STEPS  = HASH_W / MOD_BITS;
    localparam int STEP_CNT_W = 3;

    // one byte of the elf/pjw hash
    function automatic logic [HASH_W-1:0] pjw_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [31:0] t;
        logic [31:0] g;
        begin
            t = 32'(h) * HASH_MUL + 32'(b);
            g = t & HASH_TOP;
            if (g != 32'd0) begin
                t = (t ^ (g >> HASH_FOLD)) & ~HASH_TOP;
            end
            return t[HASH_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/chti_hash.sv =====
// chti_hash: byte-serial elf/pjw hash of a key, then radix-16 restoring
// reduction modulo the bucket count; depends on chti_pkg
module chti_hash import chti_pkg::*; #(
    parameter int KEY_BYTES = DEF_KEY_BYTES,
    parameter int DIV_W     = CFG_W,
    parameter int BKT_IDX_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [8*KEY_BYTES-1:0] i_key,
    input  logic [DIV_W-1:0]       i_buckets,
    output logic                   o_done,
    output logic [BKT_IDX_W-1:0]   o_bucket
);

    localparam int KEY_BITS = 8 * KEY_BYTES;

    logic                  r_busy;
    logic                  r_mod;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [KEY_BITS-1:0]   r_key;
    logic [HASH_W-1:0]     r_hash;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_div;

    // four restoring steps, remainder stays below the divisor
    function automatic logic [DIV_W-1:0] mod_step(input logic [DIV_W-1:0] rem,
                                                  input logic [MOD_BITS-1:0] bits,
                                                  input logic [DIV_W-1:0] div);
        logic [DIV_W:0] t;
        int k;
        begin
            t = {1'b0, rem};
            for (k = 0; k < MOD_BITS; k++) begin
                t = {t[DIV_W-1:0], bits[MOD_BITS-1-k]};
                if (t >= {1'b0, div}) begin
                    t = t - {1'b0, div};
                end
            end
            return t[DIV_W-1:0];
        end
    endfunction

    // control: hash phase then modulo phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mod  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_mod && !i_start && (r_cnt == STEP_CNT_W'(MOD_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_mod  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy && !r_mod) begin
                if (r_cnt == STEP_CNT_W'(KEY_BYTES - 1)) begin
                    r_mod <= 1'b1;
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == STEP_CNT_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath: key shifts out a byte a cycle, hash shifts out a nibble a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_div  <= i_buckets;
            r_hash <= '0;
            r_rem  <= '0;
        end else if (r_busy && !r_mod) begin
            r_hash <= pjw_step(r_hash, r_key[7:0]);
            r_key  <= r_key >> 8;
        end else if (r_busy) begin
            r_rem  <= mod_step(r_rem, r_hash[HASH_W-1 -: MOD_BITS], r_div);
            r_hash <= r_hash << MOD_BITS;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BKT_IDX_W-1:0];

endmodule

// ===== hdl/chained_hash_table_insert_find.sv =====
// chained_hash_table_insert_find: top level of the chained hash set, with
// head and entry memories, chain walk and apb registers; depends on chti_pkg
// and chti_hash
//
// Use: a request beat on s_axis carries the key in tdata and the command in
// tuser (insert if absent, or find). One result beat per request leaves on
// m_axis: entry index in tdata, status in tuser.
// A request passes through the byte-serial hash, the 4-bit-per-cycle modulo
// unit, the head read and then a registered read of the entry memory per
// chain entry compared; a hit ends the walk at the matching entry, while an
// empty bucket or a miss goes through the miss state, which inserts or sets
// the status. One request is in flight at a time; the next request beat is
// taken once the result of the previous one has been placed in the output
// register, even if that register still waits to be taken.
// Reset: after reset the head memory is swept to empty, one bucket a cycle,
// during which s_axis_tready stays low. The entry count returns to zero,
// bucket_count and entry_limit to 256. Registers may be written during the
// sweep.
// Stall: while m_axis_tready is low the result is held in the output register
// and a finished request waits for it before its own result is loaded.
module chained_hash_table_insert_find import chti_pkg::*; #(
    parameter int KEY_BYTES   = DEF_KEY_BYTES,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [8*KEY_BYTES-1:0] s_axis_tdata,   // [8*KEY_BYTES-1:0] key
    input  logic [0:0]             s_axis_tuser,   // [0] cmd
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] entry_index
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int KEY_BITS  = 8 * KEY_BYTES;
    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int BKT_IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int BKT_W     = $clog2(MAX_BUCKETS + 1);
    localparam int DIV_W     = (BKT_W > CFG_W) ? BKT_W : CFG_W;
    localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LINK_W    = IDX_W + 1;
    localparam int ENT_W     = LINK_W + KEY_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_HEAD  = 8'b0000_1000,
        S_HCHK  = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_MISS  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_bucket_count;
    logic [CFG_W-1:0]     r_entry_limit;
    logic [CNT_W-1:0]     r_count;
    logic [BKT_IDX_W-1:0] r_clr_addr;
    logic                 r_cmd;
    logic [KEY_BITS-1:0]  r_key;
    logic [IDX_W-1:0]     r_node;
    t_status              r_res_status;
    logic [IDX_W-1:0]     r_res_idx;
    logic                 r_m_valid;
    logic [7:0]           r_m_idx;
    t_status              r_m_status;

    // memories: head per bucket {valid, index}, entry {next valid, next, key}
    logic [LINK_W-1:0]    r_heads [MAX_BUCKETS];
    logic [ENT_W-1:0]     r_ents  [MAX_ENTRIES];
    logic [LINK_W-1:0]    r_head_q;
    logic [ENT_W-1:0]     r_ent_q;

    logic                 s_beat;
    logic                 cfg_wr;
    logic [DIV_W-1:0]     bkt_cfg;
    logic [DIV_W-1:0]     eff_buckets;
    logic [LIM_W-1:0]     lim_cfg;
    logic [LIM_W-1:0]     eff_limit;
    logic                 table_full;
    logic                 hash_start;
    logic                 hash_done;
    logic [BKT_IDX_W-1:0] bucket;
    logic                 ent_rd;
    logic [IDX_W-1:0]     ent_rd_addr;
    logic                 key_hit;
    logic                 next_valid;
    logic [IDX_W-1:0]     next_idx;
    logic                 do_insert;
    logic                 out_load;
    logic [IDX_W+7:0]     res_idx_ext;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= RST_BUCKETS;
            r_entry_limit  <= RST_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BUCKETS: r_bucket_count <= pwdata[CFG_W-1:0];
                REG_LIMIT:   r_entry_limit  <= pwdata[CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BUCKETS: prdata = PDATA_W'(r_bucket_count);
            REG_LIMIT:   prdata = PDATA_W'(r_entry_limit);
            default:     prdata = '0;
        endcase
    end

    // effective bucket count and entry limit
    assign bkt_cfg = DIV_W'(r_bucket_count);
    assign eff_buckets = (bkt_cfg == '0) ? DIV_W'(1) :
                         (bkt_cfg > DIV_W'(MAX_BUCKETS)) ? DIV_W'(MAX_BUCKETS) : bkt_cfg;
    assign lim_cfg   = LIM_W'(r_entry_limit);
    assign eff_limit = (lim_cfg > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : lim_cfg;
    assign table_full = (LIM_W'(r_count) >= eff_limit);

    // hash and bucket selection
    assign hash_start = s_beat;

    chti_hash #(
        .KEY_BYTES (KEY_BYTES),
        .DIV_W     (DIV_W),
        .BKT_IDX_W (BKT_IDX_W)
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (hash_start),
        .i_key     (s_axis_tdata),
        .i_buckets (eff_buckets),
        .o_done    (hash_done),
        .o_bucket  (bucket)
    );

    // chain walk decode
    assign key_hit    = (r_ent_q[KEY_BITS-1:0] == r_key);
    assign next_valid = r_ent_q[ENT_W-1];
    assign next_idx   = r_ent_q[KEY_BITS +: IDX_W];
    assign do_insert  = (r_state == S_MISS) && (r_cmd == CMD_INSERT) && !table_full;

    always_comb begin
        ent_rd      = 1'b0;
        ent_rd_addr = r_head_q[IDX_W-1:0];
        if (r_state == S_HCHK) begin
            ent_rd = r_head_q[IDX_W];
        end else if (r_state == S_WALK && !key_hit) begin
            ent_rd      = next_valid;
            ent_rd_addr = next_idx;
        end
    end

    // head memory: clearing sweep and insert write, read when bucket known
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_heads[r_clr_addr] <= '0;
        end else if (do_insert) begin
            r_heads[bucket] <= {1'b1, r_count[IDX_W-1:0]};
        end
        if (r_state == S_HEAD) begin
            r_head_q <= r_heads[bucket];
        end
    end

    // entry memory: new entry links to the old head
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_ents[r_count[IDX_W-1:0]] <= {r_head_q, r_key};
        end
        if (ent_rd) begin
            r_ent_q <= r_ents[ent_rd_addr];
        end
    end

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == BKT_IDX_W'(MAX_BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_beat) n_state = S_HASH;
            S_HASH:  if (hash_done) n_state = S_HEAD;
            S_HEAD:  n_state = S_HCHK;
            S_HCHK:  n_state = r_head_q[IDX_W] ? S_WALK : S_MISS;
            S_WALK: begin
                if (key_hit) begin
                    n_state = S_RESP;
                end else if (!next_valid) begin
                    n_state = S_MISS;
                end
            end
            S_MISS:  n_state = S_RESP;
            S_RESP:  if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (do_insert) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // request capture, key bits are all significant at this width
    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_cmd <= s_axis_tuser[0];
            r_key <= s_axis_tdata;
        end
    end

    // current node and result
    always_ff @(posedge i_clk) begin
        if (r_state == S_HCHK) begin
            r_node <= r_head_q[IDX_W-1:0];
        end else if (r_state == S_WALK) begin
            if (key_hit) begin
                r_res_status <= ST_FOUND;
                r_res_idx    <= r_node;
            end else begin
                r_node <= next_idx;
            end
        end else if (r_state == S_MISS) begin
            if (r_cmd == CMD_FIND) begin
                r_res_status <= ST_NOT_FOUND;
                r_res_idx    <= '0;
            end else if (table_full) begin
                r_res_status <= ST_FULL;
                r_res_idx    <= '0;
            end else begin
                r_res_status <= ST_INSERTED;
                r_res_idx    <= r_count[IDX_W-1:0];
            end
        end
    end

    // output register
    assign out_load    = (r_state == S_RESP) && (!r_m_valid || m_axis_tready);
    assign res_idx_ext = {8'd0, r_res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_idx    <= res_idx_ext[7:0];
            r_m_status <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_idx;
    assign m_axis_tuser  = r_m_status;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(MAX_ENTRIES) >= r_count)
        else $error("entry count beyond table size");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance entry count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_m_valid || m_axis_tready))
        else $error("result loaded over an untaken beat");

    a_hash_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("hash finished outside hash state");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request taken during head sweep");

endmodule

// ===== dv/tb_chained_hash_table_insert_find.sv =====
// tb_chained_hash_table_insert_find: self-checking bench for the chained hash set,
// with stream driver, result monitor, apb register writes and a behavioural model
// depends on chti_pkg and chained_hash_table_insert_find
module tb_chained_hash_table_insert_find;
    import chti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        cmd;
        logic [63:0] key;
    } request_t;

    typedef struct packed {
        t_status    status;
        logic [7:0] index;
    } answer_t;

    // register settings for the random phases, applied in order
    localparam int N_PHASES = 12;
    localparam int PHASE_LEN = 120;
    localparam int PH_BUCKETS [N_PHASES] = '{16, 3, 256, 1, 0, 511, 97, 255, 2, 256, 173, 128};
    localparam int PH_LIMIT   [N_PHASES] = '{60, 100, 140, 170, 0, 200, 511, 256, 256, 256,
                                             256, 5};
    localparam int PH_INS_PCT [N_PHASES] = '{55, 45, 45, 40, 50, 40, 40, 35, 35, 40, 40, 50};
    localparam int STEADY_PHASE = 2;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata = '0;    // [63:0] key
    logic [0:0]         s_axis_tuser = '0;    // [0] cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;         // [7:0] entry_index
    logic [1:0]         m_axis_tuser;         // [1:0] status
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    chained_hash_table_insert_find dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench bookkeeping
    request_t    queued_requests[$];
    answer_t     awaited_answers[$];
    logic [63:0] seen_keys[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_settings = 0;
    int          n_by_status[4] = '{0, 0, 0, 0};
    logic        steady = 1'b0;
    logic        hold_used = 1'b0;
    int          hold_left = 0;

    // model state: configuration, bucket heads, chain links, stored keys
    int unsigned cfg_buckets = 256;
    int unsigned cfg_limit = 256;
    int unsigned head_of [DEF_MAX_BUCKETS];
    bit          head_used [DEF_MAX_BUCKETS];
    int unsigned link_of [DEF_MAX_ENTRIES];
    bit          link_used [DEF_MAX_ENTRIES];
    logic [63:0] stored_key [DEF_MAX_ENTRIES];
    int unsigned n_entries = 0;

    // elf/pjw hash over the key bytes, byte 0 first
    function automatic logic [31:0] pjw_of(input logic [63:0] key);
        logic [31:0] h;
        logic [31:0] top;
        h = '0;
        for (int i = 0; i < DEF_KEY_BYTES; i++) begin
            h = h * HASH_MUL + 32'(key[8*i +: 8]);
            top = h & HASH_TOP;
            if (top != 0) begin
                h = (h ^ (top >> HASH_FOLD)) & ~HASH_TOP;
            end
        end
        return h;
    endfunction

    // walk the bucket chain newest first; on an insert, add at the head when absent and below the limit
    function automatic answer_t lookup_or_insert(input logic cmd, input logic [63:0] key);
        answer_t     ans;
        int unsigned nb;
        int unsigned lim;
        int unsigned bucket;
        int unsigned node;
        int unsigned steps;
        bit          have;
        nb = (cfg_buckets == 0) ? 1 : cfg_buckets;
        if (nb > DEF_MAX_BUCKETS) nb = DEF_MAX_BUCKETS;
        lim = (cfg_limit > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : cfg_limit;
        bucket = pjw_of(key) % nb;
        node = head_of[bucket];
        have = head_used[bucket];
        steps = 0;
        while (have && steps < n_entries && node < DEF_MAX_ENTRIES) begin
            if (stored_key[node] == key) begin
                ans.status = ST_FOUND;
                ans.index = 8'(node);
                return ans;
            end
            have = link_used[node];
            node = link_of[node];
            steps++;
        end
        ans.index = '0;
        if (cmd == CMD_FIND) begin
            ans.status = ST_NOT_FOUND;
        end else if (n_entries >= lim) begin
            ans.status = ST_FULL;
        end else begin
            link_of[n_entries] = head_of[bucket];
            link_used[n_entries] = head_used[bucket];
            stored_key[n_entries] = key;
            head_of[bucket] = n_entries;
            head_used[bucket] = 1'b1;
            ans.status = ST_INSERTED;
            ans.index = 8'(n_entries);
            n_entries++;
        end
        return ans;
    endfunction

    // random request: known keys most often, then fresh keys, near misses and corner keys
    function automatic request_t random_request(input int unsigned insert_pct);
        request_t    r;
        int unsigned pick;
        r.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_FIND;
        pick = $urandom_range(0, 99);
        if (seen_keys.size() == 0 || pick < 35) begin
            r.key = {$urandom, $urandom};
        end else if (pick < 85) begin
            r.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        end else if (pick < 95) begin
            r.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)]
                    ^ (64'd1 << $urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 3))
                0: r.key = '0;
                1: r.key = '1;
                2: r.key = 64'd1 << $urandom_range(0, 63);
                default: r.key = ~(64'd1 << $urandom_range(0, 63));
            endcase
        end
        return r;
    endfunction

    task automatic queue_request(input logic cmd, input logic [63:0] key);
        queued_requests.push_back('{cmd: cmd, key: key});
        if (cmd == CMD_INSERT) seen_keys.push_back(key);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write both registers, mirror them in the model, read them back
    task automatic configure(input int unsigned buckets, input int unsigned limit);
        logic [PDATA_W-1:0] rd;
        apb_write({REG_BUCKETS, 2'b00}, PDATA_W'(buckets));
        apb_write({REG_LIMIT, 2'b00}, PDATA_W'(limit));
        cfg_buckets = buckets & 9'h1FF;
        cfg_limit = limit & 9'h1FF;
        apb_read({REG_BUCKETS, 2'b00}, rd);
        if (rd[CFG_W-1:0] !== CFG_W'(cfg_buckets)) begin
            n_errors++;
            if (n_errors <= 10)
                $display("bucket_count readback: expected %0d, got %0d", cfg_buckets, rd);
        end
        apb_read({REG_LIMIT, 2'b00}, rd);
        if (rd[CFG_W-1:0] !== CFG_W'(cfg_limit)) begin
            n_errors++;
            if (n_errors <= 10)
                $display("entry_limit readback: expected %0d, got %0d", cfg_limit, rd);
        end
        n_settings++;
    endtask

    // wait until every queued request has gone in and every answer has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || s_axis_tvalid || awaited_answers.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // request driver: offer the next queued beat with random gaps, none in the steady phase
    always @(posedge i_clk) begin
        request_t next_req;
        if (!s_axis_tvalid || s_axis_tready) begin
            if (queued_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
                next_req = queued_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_req.key;
                s_axis_tuser <= next_req.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result ready: random stalls outside the steady phase, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!hold_used && n_results == HOLD_AT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // monitor: check result beats first, then predict accepted request beats
    always @(posedge i_clk) begin
        answer_t fresh;
        answer_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results <= n_results + 1;
                if (awaited_answers.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result beat: status %0d index %0d",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== want.index) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: status expected %0d got %0d, index expected %0d got %0d",
                                     n_results, want.status, m_axis_tuser,
                                     want.index, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fresh = lookup_or_insert(s_axis_tuser[0], s_axis_tdata);
                n_by_status[fresh.status]++;
                awaited_answers.push_back(fresh);
            end
        end
    end

    // stimulus: directed corner cases, then random phases over several settings
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table at reset settings
        queue_request(CMD_FIND, 64'h0);
        queue_request(CMD_FIND, '1);
        wait_idle();

        // zero bucket count and zero entry limit
        configure(0, 0);
        queue_request(CMD_INSERT, 64'h0);
        queue_request(CMD_INSERT, '1);
        queue_request(CMD_FIND, 64'h8000_0000_0000_0000);
        wait_idle();

        // oversized bucket count, one entry allowed; full table still finds
        configure(511, 1);
        queue_request(CMD_INSERT, 64'h0);
        queue_request(CMD_INSERT, 64'h0);
        queue_request(CMD_INSERT, '1);
        queue_request(CMD_FIND, 64'h0);
        queue_request(CMD_FIND, '1);
        wait_idle();

        // single bucket, oversized limit: one long chain, near-miss keys
        configure(1, 300);
        queue_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(CMD_INSERT, 64'h5555_5555_5555_5555);
        queue_request(CMD_INSERT, 64'h8000_0000_0000_0000);
        queue_request(CMD_INSERT, 64'h0000_0000_0000_0001);
        queue_request(CMD_INSERT, 64'h0000_0000_0000_00FF);
        queue_request(CMD_INSERT, 64'hFF00_0000_0000_0000);
        queue_request(CMD_FIND, 64'h0);
        queue_request(CMD_FIND, 64'h8000_0000_0000_0000);
        queue_request(CMD_FIND, 64'h0000_0000_0000_0002);
        queue_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_idle();

        // bucket count changed with entries in place
        configure(7, 300);
        queue_request(CMD_FIND, 64'h5555_5555_5555_5555);
        queue_request(CMD_INSERT, 64'h5555_5555_5555_5555);
        queue_request(CMD_FIND, 64'h0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            configure(PH_BUCKETS[p], PH_LIMIT[p]);
            steady <= (p == STEADY_PHASE);
            for (int i = 0; i < PHASE_LEN; i++) begin
                request_t r;
                r = random_request(PH_INS_PCT[p]);
                queue_request(r.cmd, r.key);
            end
            wait_idle();
        end

        // tail: allow for any stray beat after the last answer
        repeat (300) @(negedge i_clk);
        $display("%0d requests over %0d register settings, %0d entries stored", n_results,
                 n_settings, n_entries);
        $display("statuses: %0d found, %0d inserted, %0d not found, %0d full",
                 n_by_status[ST_FOUND], n_by_status[ST_INSERTED],
                 n_by_status[ST_NOT_FOUND], n_by_status[ST_FULL]);
        if (n_errors == 0) begin
            $display("[chained_hash_table_insert_find] OK");
        end else begin
            $display("[chained_hash_table_insert_find] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("[chained_hash_table_insert_find] ERROR");
        $finish;
    end

endmodule

// ===== chained_hash_table_insert_find.f =====
hdl/chti_pkg.sv
hdl/chti_hash.sv
hdl/chained_hash_table_insert_find.sv
dv/tb_chained_hash_table_insert_find.sv
